[rtl/aets_pkg.sv]
// shared types and constants for the echo threshold statistics block
`default_nettype none

package aets_pkg;

  // width of the per-frame running sums
  localparam int unsigned SumW = 11;
  // width of the averages on the output
  localparam int unsigned AvgW = 7;
  // width of a scaled numerator, avg * 255 plus rounding term
  localparam int unsigned NumW = 15;

  localparam logic [7:0] ThresholdReset = 8'd10;
  localparam logic [7:0] ScatterBase    = 8'd65;
  localparam logic [7:0] HeightBase     = 8'd200;
  localparam logic [7:0] FullScale      = 8'd255;

  // one finished frame handed from the front to the back
  typedef struct packed {
    logic [SumW-1:0] first_sum;
    logic [SumW-1:0] count_sum;
  } frame_sums_t;

endpackage

`default_nettype wire

[rtl/aets_front.sv]
// front end: threshold compare, per-waveform crossing search and frame sums
`default_nettype none

module aets_front #(
  parameter int unsigned SamplesPerWaveform = 104,
  parameter int unsigned WaveformsPerFrame  = 8
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire  [7:0]           cfg_wdata_i,
  input  wire                  accept_i,
  input  wire  [7:0]           sample_i,
  input  wire                  frame_start_i,
  output logic                 push_o,
  output aets_pkg::frame_sums_t sums_o
);

  localparam int unsigned PosW = $clog2(SamplesPerWaveform);
  localparam int unsigned WavW = (WaveformsPerFrame > 1) ? $clog2(WaveformsPerFrame) : 1;
  localparam logic [PosW-1:0] LastPos = PosW'(SamplesPerWaveform - 1);
  localparam logic [WavW-1:0] LastWav = WavW'(WaveformsPerFrame - 1);

  logic [7:0]                  thr_q;
  logic [PosW-1:0]             pos_q, pos_d;
  logic [WavW-1:0]             wav_q, wav_d;
  logic                        found_q, found_d;
  logic [PosW-1:0]             first_q, first_d;
  logic [aets_pkg::SumW-1:0]   fsum_q, fsum_d;
  logic [aets_pkg::SumW-1:0]   csum_q, csum_d;

  logic [PosW-1:0]             pos, first, first_n;
  logic [WavW-1:0]             wav;
  logic                        found, found_n, above;
  logic [aets_pkg::SumW-1:0]   fsum, csum, csum_n, fsum_n;

  always_comb begin
    // a frame start drops any partial frame before this word is used
    pos   = frame_start_i ? '0 : pos_q;
    wav   = frame_start_i ? '0 : wav_q;
    found = frame_start_i ? 1'b0 : found_q;
    first = frame_start_i ? '0 : first_q;
    fsum  = frame_start_i ? '0 : fsum_q;
    csum  = frame_start_i ? '0 : csum_q;

    above   = sample_i > thr_q;
    csum_n  = csum + aets_pkg::SumW'(above);
    found_n = found | above;
    first_n = (above && !found) ? pos : first;
    fsum_n  = fsum + (found_n ? aets_pkg::SumW'(first_n) : '0);

    pos_d   = pos_q;
    wav_d   = wav_q;
    found_d = found_q;
    first_d = first_q;
    fsum_d  = fsum_q;
    csum_d  = csum_q;
    push_o  = 1'b0;
    sums_o.first_sum = fsum_n;
    sums_o.count_sum = csum_n;

    if (accept_i) begin
      if (pos != LastPos) begin
        pos_d   = pos + PosW'(1);
        wav_d   = wav;
        found_d = found_n;
        first_d = first_n;
        fsum_d  = fsum;
        csum_d  = csum_n;
      end else begin
        pos_d   = '0;
        found_d = 1'b0;
        first_d = '0;
        if (wav != LastWav) begin
          wav_d  = wav + WavW'(1);
          fsum_d = fsum_n;
          csum_d = csum_n;
        end else begin
          // end of frame: hand the sums over and start clean
          push_o = 1'b1;
          wav_d  = '0;
          fsum_d = '0;
          csum_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= aets_pkg::ThresholdReset;
      pos_q   <= '0;
      wav_q   <= '0;
      found_q <= 1'b0;
      first_q <= '0;
      fsum_q  <= '0;
      csum_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      pos_q   <= pos_d;
      wav_q   <= wav_d;
      found_q <= found_d;
      first_q <= first_d;
      fsum_q  <= fsum_d;
      csum_q  <= csum_d;
    end
  end

endmodule

`default_nettype wire

[rtl/aets_fifo.sv]
// short queue of finished frame sums between front and back
`default_nettype none

module aets_fifo (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  aets_pkg::frame_sums_t push_data_i,
  output logic                  full_o,
  input  wire                   pop_i,
  output logic                  empty_o,
  output aets_pkg::frame_sums_t pop_data_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  aets_pkg::frame_sums_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o     = (count_q == (PtrW+1)'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (PtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PtrW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/aets_back.sv]
// back end: averaging, scaling and clamping pipeline with output register
`default_nettype none

module aets_back #(
  parameter int unsigned SamplesPerWaveform = 104,
  parameter int unsigned WaveformsPerFrame  = 8
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   empty_i,
  input  aets_pkg::frame_sums_t sums_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic [7:0]            scatter_o,
  output logic [7:0]            height_o,
  output logic [aets_pkg::AvgW-1:0] avg_first_o,
  output logic [aets_pkg::AvgW-1:0] avg_count_o
);

  localparam int unsigned SumW = aets_pkg::SumW;
  localparam int unsigned AvgW = aets_pkg::AvgW;
  localparam int unsigned NumW = aets_pkg::NumW;

  // reciprocal of the waveform count, exact for every sum below 2**SumW
  localparam int unsigned Shift1 = SumW + $clog2(WaveformsPerFrame);
  localparam int unsigned Recip1 = ((1 << Shift1) + WaveformsPerFrame - 1) / WaveformsPerFrame;
  localparam int unsigned Prod1W = SumW + SumW + 1;

  // reciprocal of the waveform length, exact for every numerator below 2**NumW
  localparam int unsigned Shift2 = NumW + $clog2(SamplesPerWaveform);
  localparam int unsigned Recip2 = ((1 << Shift2) + SamplesPerWaveform - 1) / SamplesPerWaveform;
  localparam int unsigned Prod2W = NumW + NumW + 1;
  localparam int unsigned QuotW  = NumW + 1;

  localparam logic [SumW:0]   Recip1C  = (SumW+1)'(Recip1);
  localparam logic [NumW:0]   Recip2C  = (NumW+1)'(Recip2);
  localparam logic [NumW-1:0] RoundAdd = NumW'(SamplesPerWaveform - 1);

  logic advance;
  logic v1_q, v2_q, v3_q;

  logic [Prod1W-1:0] fprod_q, cprod_q;
  logic [AvgW-1:0]   afirst_q, acnt_q;
  logic [Prod2W-1:0] upprod_q, scprod_q;
  logic [7:0]        scatter_q, height_q;
  logic [AvgW-1:0]   afirst_out_q, acnt_out_q;

  logic [AvgW-1:0]   afirst, acnt;
  logic [NumW-1:0]   up_num, sc_num;
  logic [QuotW-1:0]  up, sc;
  logic [7:0]        scatter_d, height_d;

  // whole pipeline moves together whenever the output word can leave
  assign advance = !v3_q || out_ready_i;
  assign pop_o   = advance && !empty_i;

  always_comb begin
    afirst = fprod_q[Shift1 +: AvgW];
    acnt   = cprod_q[Shift1 +: AvgW];
    // x * 255 as (x << 8) - x
    up_num = ({afirst, 8'd0} - NumW'(afirst)) + RoundAdd;
    sc_num = {acnt, 8'd0} - NumW'(acnt);

    up = QuotW'(upprod_q >> Shift2);
    sc = QuotW'(scprod_q >> Shift2);

    if (sc >= QuotW'(aets_pkg::FullScale - aets_pkg::ScatterBase)) begin
      scatter_d = aets_pkg::FullScale;
    end else begin
      scatter_d = aets_pkg::ScatterBase + sc[7:0];
    end

    if (up >= QuotW'(aets_pkg::HeightBase)) begin
      height_d = '0;
    end else begin
      height_d = aets_pkg::HeightBase - up[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fprod_q      <= Prod1W'(sums_i.first_sum * Recip1C);
      cprod_q      <= Prod1W'(sums_i.count_sum * Recip1C);
      afirst_q     <= afirst;
      acnt_q       <= acnt;
      upprod_q     <= Prod2W'(up_num * Recip2C);
      scprod_q     <= Prod2W'(sc_num * Recip2C);
      afirst_out_q <= afirst_q;
      acnt_out_q   <= acnt_q;
      scatter_q    <= scatter_d;
      height_q     <= height_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (advance) begin
      v1_q <= !empty_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign scatter_o   = scatter_q;
  assign height_o    = height_q;
  assign avg_first_o = afirst_out_q;
  assign avg_count_o = acnt_out_q;

endmodule

`default_nettype wire

[rtl/altimeter_echo_threshold_stats.sv]
// top level of the radar echo threshold statistics block
//
// input stream: one 8-bit echo sample per word in s_axis_tdata, s_axis_tuser
// set on the first sample of a frame to drop any partial frame. a frame is
// WaveformsPerFrame waveforms of SamplesPerWaveform samples.
// output stream: one word per completed frame with scatter level, height
// level and the two floor averages. cfg_we_i/cfg_wdata_i write the echo
// threshold (reset value 10); write it only while the block is idle.
// throughput: one sample per cycle while s_axis_tready is high. the front
// keeps the per-sample compare and sums, a four-entry queue holds finished
// frames, and a three-stage back pipeline (two reciprocal multiplies) forms
// the result. the sums of a frame enter the queue when its last sample is
// taken, then pass through the three back stages to the output register.
// stalls: when m_axis_tready is low with a result word waiting, the back
// pipeline holds; the front keeps taking samples until four finished frames
// wait in the queue, then s_axis_tready drops.
// reset: counters, sums and the queue clear, the threshold returns to 10.
`default_nettype none

module altimeter_echo_threshold_stats #(
  parameter int unsigned SamplesPerWaveform = 104,
  parameter int unsigned WaveformsPerFrame  = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [7:0]  cfg_wdata_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] sample
  input  wire         s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [7:0] scatter_level, [15:8] height_level, [22:16] avg_first_index,
  // [29:23] avg_count, [31:30] zero
  output logic [31:0] m_axis_tdata
);

  logic                  accept, push, full, empty, pop;
  aets_pkg::frame_sums_t push_sums, pop_sums;
  logic [7:0]            scatter, height;
  logic [aets_pkg::AvgW-1:0] avg_first, avg_count;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  aets_front #(
    .SamplesPerWaveform (SamplesPerWaveform),
    .WaveformsPerFrame  (WaveformsPerFrame)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .sample_i      (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .push_o        (push),
    .sums_o        (push_sums)
  );

  aets_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_sums),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_sums)
  );

  aets_back #(
    .SamplesPerWaveform (SamplesPerWaveform),
    .WaveformsPerFrame  (WaveformsPerFrame)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .sums_i      (pop_sums),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .scatter_o   (scatter),
    .height_o    (height),
    .avg_first_o (avg_first),
    .avg_count_o (avg_count)
  );

  assign m_axis_tdata = {2'b00, avg_count, avg_first, height, scatter};

endmodule

`default_nettype wire
